@@ design/bglm_pkg.sv @@
// Shared types, constants and helper functions for the bar graph LED matrix driver.
// No dependencies; every other design file imports this package.
package bglm_pkg;

    // Matrix geometry
    localparam int unsigned ROW_COUNT   = 8;
    localparam int unsigned PLANE_COUNT = 8;
    localparam int unsigned ROW_W       = $clog2(ROW_COUNT);
    localparam int unsigned PLANE_W     = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // Color band boundaries for the three-band and two-band modes
    localparam int unsigned BAND_HALF  = ROW_COUNT / 2;
    localparam int unsigned BAND_THIRD = ROW_COUNT / 3;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Request type codes
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Banding mode codes
    localparam logic [3:0] MODE_ONE   = 4'd1;
    localparam logic [3:0] MODE_TWO   = 4'd2;
    localparam logic [3:0] MODE_THREE = 4'd3;

    // Color slot codes
    localparam logic [3:0] SLOT_PRIMARY   = 4'd1;
    localparam logic [3:0] SLOT_SECONDARY = 4'd2;
    localparam logic [3:0] SLOT_TERTIARY  = 4'd3;

    localparam logic [15:0] BASE_PERIOD_RESET = 16'd288;
    localparam logic [7:0]  CHAN_OFF          = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t PRIMARY_RESET   = '{red: 8'h1E, green: 8'h81, blue: 8'hB0};
    localparam rgb_t SECONDARY_RESET = '{red: 8'h6C, green: 8'h25, blue: 8'hBE};
    localparam rgb_t TERTIARY_RESET  = '{red: 8'hBE, green: 8'hA9, blue: 8'h25};
    localparam rgb_t ALL_OFF         = '{red: CHAN_OFF, green: CHAN_OFF, blue: CHAN_OFF};

    typedef enum logic {
        CMD_TICK,
        CMD_PAINT
    } cmd_kind_t;

    // One queued command: either a tick with its resolved row/plane, or a
    // store rebuild with the colors in effect at the time it was accepted.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [3:0]         mode;
        logic [31:0]        levels;
        rgb_t               primary;
        rgb_t               secondary;
        rgb_t               tertiary;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
    } cmd_t;

    // Active-low column marks for one row: a 0 bit lights the column.
    function automatic logic [7:0] row_marks(input logic [ROW_W-1:0] row,
                                             input logic [31:0] levels);
        logic [ROW_W-1:0] up;
        logic [3:0]       h;
        logic [7:0]       m;
        up = ROW_W'(ROW_COUNT - 1) - row;
        m  = '0;
        for (int j = 0; j < 8; j++) begin
            h = levels[28 - 4 * j +: 4];
            m[7 - j] = (h <= 4'(up));
        end
        return m;
    endfunction

    // Channel byte for one plane: the marks when the color bit is set, else off.
    function automatic logic [7:0] chan_byte(input logic [7:0] chan,
                                             input logic [PLANE_W-1:0] plane,
                                             input logic [7:0] marks);
        return chan[plane] ? marks : CHAN_OFF;
    endfunction

endpackage

@@ design/bar_graph_led_matrix_bcm_driver_top.sv @@
// Top level of the bar graph LED matrix driver with binary-code modulation.
// Depends on bglm_pkg, bglm_front, bglm_queue and bglm_back.
//
// Input channel (push/full): a beat is a frame update (req_type 0) or a display
//   tick (req_type 1). A frame update may replace one of the three colors and,
//   for modes 1 to 3, rebuilds the active-low bitplane store from the heights.
// Result channel (empty/pop): each tick yields one beat with the row, the plane,
//   the channel bytes, the plane-0 blank flag and the next period length.
// Configuration: cfg_wr_en/cfg_wr_data write the base period; write only while idle.
// Timing: a tick passes through the command queue, the registered store read
//   and the result register before its result shows. A tick cannot start its
//   lookup while the result register is full, so it waits until the previous
//   result is popped. A rebuild holds the back end while it takes the command
//   and makes ROW_COUNT*PLANE_COUNT (64) writes through the single write port;
//   a color-only update costs no back-end time. The two-deep queue raises full
//   only once two commands wait behind the back end.
// Reset: colors, counters and base period return to defaults; the store reads
//   as all off through one valid bit per row, with no clear pass.
// Stalls: while pop is low the result holds; further ticks fill the queue and
//   then hold off the input through full.
module bar_graph_led_matrix_bcm_driver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [3:0]  mode,
    input  logic [3:0]  color_slot,
    input  logic [31:0] levels,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  row_index,
    output logic [2:0]  plane_index,
    output logic        blank_first,
    output logic [7:0]  blue_bits,
    output logic [7:0]  green_bits,
    output logic [7:0]  red_bits,
    output logic [22:0] period_cycles
);
    import bglm_pkg::*;

    // Front to queue
    logic q_wr_en;
    cmd_t q_wr_entry;
    logic q_full;

    // Queue to back
    logic q_rd_en;
    cmd_t q_rd_entry;
    logic q_empty;

    // Front: accept beats, apply color slots, resolve tick row/plane.
    bglm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .mode       (mode),
        .color_slot (color_slot),
        .levels     (levels),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .q_push     (q_wr_en),
        .q_entry    (q_wr_entry),
        .q_full     (q_full)
    );

    // Queue: decouple acceptance from the rebuilds.
    bglm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    // Back: paint the store, look up ticks, hold the result beat.
    bglm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_empty       (q_empty),
        .q_entry       (q_rd_entry),
        .q_pop         (q_rd_en),
        .empty         (empty),
        .pop           (pop),
        .row_index     (row_index),
        .plane_index   (plane_index),
        .blank_first   (blank_first),
        .blue_bits     (blue_bits),
        .green_bits    (green_bits),
        .red_bits      (red_bits),
        .period_cycles (period_cycles)
    );

endmodule

@@ design/bglm_front.sv @@
// Front end: accepts beats, keeps the color set and tick counters, queues commands.
// Depends on bglm_pkg.
module bglm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  req_type,
    input  logic [3:0]            mode,
    input  logic [3:0]            color_slot,
    input  logic [31:0]           levels,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output logic                  q_push,
    output bglm_pkg::cmd_t        q_entry,
    input  logic                  q_full
);
    import bglm_pkg::*;

    rgb_t               primary_reg, primary_next;
    rgb_t               secondary_reg, secondary_next;
    rgb_t               tertiary_reg, tertiary_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;

    logic accept;
    logic is_frame;
    logic band_mode;
    rgb_t new_rgb;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign is_frame  = (req_type == REQ_FRAME);
    assign band_mode = (mode == MODE_ONE) || (mode == MODE_TWO) || (mode == MODE_THREE);
    assign new_rgb   = '{red: red, green: green, blue: blue};

    always_comb
    begin
        primary_next   = primary_reg;
        secondary_next = secondary_reg;
        tertiary_next  = tertiary_reg;
        row_next       = row_reg;
        plane_next     = plane_reg;
        if (accept && is_frame)
        begin
            case (color_slot)
                SLOT_PRIMARY:   primary_next   = new_rgb;
                SLOT_SECONDARY: secondary_next = new_rgb;
                SLOT_TERTIARY:  tertiary_next  = new_rgb;
                default:        ;
            endcase
        end
        // Advance through planes first, then rows.
        if (accept && !is_frame)
        begin
            if (plane_reg == PLANE_W'(PLANE_COUNT - 1))
            begin
                plane_next = '0;
                row_next   = (row_reg == ROW_W'(ROW_COUNT - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                plane_next = plane_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        q_entry.kind      = is_frame ? CMD_PAINT : CMD_TICK;
        q_entry.mode      = mode;
        q_entry.levels    = levels;
        q_entry.primary   = primary_next;
        q_entry.secondary = secondary_next;
        q_entry.tertiary  = tertiary_next;
        q_entry.row       = row_reg;
        q_entry.plane     = plane_reg;
    end

    // Drop frame updates that only change a color.
    assign q_push = accept && (!is_frame || band_mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_reg   <= PRIMARY_RESET;
            secondary_reg <= SECONDARY_RESET;
            tertiary_reg  <= TERTIARY_RESET;
            row_reg       <= '0;
            plane_reg     <= '0;
        end
        else
        begin
            primary_reg   <= primary_next;
            secondary_reg <= secondary_next;
            tertiary_reg  <= tertiary_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
        end
    end

endmodule

@@ design/bglm_queue.sv @@
// Short command queue between front and back end.
// Depends on bglm_pkg.
module bglm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bglm_pkg::cmd_t wr_entry,
    output logic           full,
    input  logic           rd_en,
    output bglm_pkg::cmd_t rd_entry,
    output logic           empty
);
    import bglm_pkg::*;

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/bglm_back.sv @@
// Back end: bitplane store, rebuild sequencer, tick lookup and result register.
// Depends on bglm_pkg.
module bglm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  q_empty,
    input  bglm_pkg::cmd_t        q_entry,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            row_index,
    output logic [2:0]            plane_index,
    output logic                  blank_first,
    output logic [7:0]            blue_bits,
    output logic [7:0]            green_bits,
    output logic [7:0]            red_bits,
    output logic [22:0]           period_cycles
);
    import bglm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PAINT
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        base_reg, base_next;
    logic [ROW_COUNT-1:0] row_valid_reg, row_valid_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [PLANE_W-1:0] cur_plane_reg, cur_plane_next;
    logic [3:0]         mode_reg, mode_next;
    logic [31:0]        levels_reg, levels_next;
    rgb_t               primary_reg, primary_next;
    rgb_t               secondary_reg, secondary_next;
    rgb_t               tertiary_reg, tertiary_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         row_out_reg, row_out_next;
    logic [2:0]         plane_out_reg, plane_out_next;
    logic               blank_out_reg, blank_out_next;
    rgb_t               bits_out_reg, bits_out_next;
    logic [22:0]        period_out_reg, period_out_next;

    // Plane store and its registered read port
    rgb_t               store_mem [ROW_COUNT][PLANE_COUNT];
    rgb_t               rd_data_reg;
    logic               rd_en;
    logic               wr_en;
    rgb_t               wr_data;

    rgb_t               band_rgb;
    logic [7:0]         marks;
    rgb_t               shown;

    assign empty         = !out_valid_reg;
    assign row_index     = row_out_reg;
    assign plane_index   = plane_out_reg;
    assign blank_first   = blank_out_reg;
    assign blue_bits     = bits_out_reg.blue;
    assign green_bits    = bits_out_reg.green;
    assign red_bits      = bits_out_reg.red;
    assign period_cycles = period_out_reg;

    // Pick the color band of the row being painted.
    always_comb
    begin
        case (mode_reg)
            MODE_TWO:
            begin
                band_rgb = (cur_row_reg < ROW_W'(BAND_HALF)) ? secondary_reg : primary_reg;
            end
            MODE_THREE:
            begin
                if (cur_row_reg < ROW_W'(BAND_THIRD))
                begin
                    band_rgb = tertiary_reg;
                end
                else if (cur_row_reg <= ROW_W'(BAND_HALF))
                begin
                    band_rgb = secondary_reg;
                end
                else
                begin
                    band_rgb = primary_reg;
                end
            end
            default: band_rgb = primary_reg;
        endcase
    end

    assign marks         = row_marks(cur_row_reg, levels_reg);
    assign wr_data.red   = chan_byte(band_rgb.red, cur_plane_reg, marks);
    assign wr_data.green = chan_byte(band_rgb.green, cur_plane_reg, marks);
    assign wr_data.blue  = chan_byte(band_rgb.blue, cur_plane_reg, marks);
    assign wr_en         = (state_reg == ST_PAINT);
    assign shown         = rd_valid_reg ? rd_data_reg : ALL_OFF;

    // Take a command only when it can proceed: a tick needs a free result register.
    assign q_pop = (state_reg == ST_IDLE) && !q_empty
                   && ((q_entry.kind == CMD_PAINT) || !out_valid_reg);
    assign rd_en = q_pop && (q_entry.kind == CMD_TICK);

    always_comb
    begin
        state_next      = state_reg;
        base_next       = cfg_wr_en ? cfg_wr_data : base_reg;
        row_valid_next  = row_valid_reg;
        rd_valid_next   = rd_valid_reg;
        cur_row_next    = cur_row_reg;
        cur_plane_next  = cur_plane_reg;
        mode_next       = mode_reg;
        levels_next     = levels_reg;
        primary_next    = primary_reg;
        secondary_next  = secondary_reg;
        tertiary_next   = tertiary_reg;
        out_valid_next  = out_valid_reg;
        row_out_next    = row_out_reg;
        plane_out_next  = plane_out_reg;
        blank_out_next  = blank_out_reg;
        bits_out_next   = bits_out_reg;
        period_out_next = period_out_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_entry.kind == CMD_TICK)
                    begin
                        cur_row_next   = q_entry.row;
                        cur_plane_next = q_entry.plane;
                        rd_valid_next  = row_valid_reg[q_entry.row];
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        cur_row_next   = '0;
                        cur_plane_next = '0;
                        mode_next      = q_entry.mode;
                        levels_next    = q_entry.levels;
                        primary_next   = q_entry.primary;
                        secondary_next = q_entry.secondary;
                        tertiary_next  = q_entry.tertiary;
                        state_next     = ST_PAINT;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next  = 1'b1;
                row_out_next    = 3'(cur_row_reg);
                plane_out_next  = 3'(cur_plane_reg);
                blank_out_next  = (cur_plane_reg == '0);
                bits_out_next   = shown;
                period_out_next = 23'(base_reg) << cur_plane_reg;
                state_next      = ST_IDLE;
            end
            ST_PAINT:
            begin
                row_valid_next[cur_row_reg] = 1'b1;
                if (cur_plane_reg == PLANE_W'(PLANE_COUNT - 1))
                begin
                    cur_plane_next = '0;
                    if (cur_row_reg == ROW_W'(ROW_COUNT - 1))
                    begin
                        cur_row_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_plane_next = cur_plane_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cur_row_reg][cur_plane_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[q_entry.row][q_entry.plane];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= BASE_PERIOD_RESET;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg   <= rd_valid_next;
        cur_row_reg    <= cur_row_next;
        cur_plane_reg  <= cur_plane_next;
        mode_reg       <= mode_next;
        levels_reg     <= levels_next;
        primary_reg    <= primary_next;
        secondary_reg  <= secondary_next;
        tertiary_reg   <= tertiary_next;
        row_out_reg    <= row_out_next;
        plane_out_reg  <= plane_out_next;
        blank_out_reg  <= blank_out_next;
        bits_out_reg   <= bits_out_next;
        period_out_reg <= period_out_next;
    end

endmodule

@@ design/bglm_checker.sv @@
// Port-level checks for the bar graph LED matrix driver, bound to the top level.
// Depends on bglm_pkg and bar_graph_led_matrix_bcm_driver_top.
module bglm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  row_index,
    input logic [2:0]  plane_index,
    input logic        blank_first,
    input logic [7:0]  blue_bits,
    input logic [7:0]  green_bits,
    input logic [7:0]  red_bits,
    input logic [22:0] period_cycles
);
    import bglm_pkg::*;

    // A waiting beat's row, plane, red bits and period hold while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(row_index) && $stable(plane_index)
                              && $stable(red_bits) && $stable(period_cycles)))
    else $error("result beat changed while stalled");

    // Blanking goes with plane zero only.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (blank_first == (plane_index == 3'd0)))
    else $error("blank_first does not match plane_index");

    // The period is the base shifted by the plane: its low plane bits are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((period_cycles & ~(23'h7FFFFF << plane_index)) == 23'd0))
    else $error("period_cycles not aligned to plane_index");

    // A taken beat is never followed by a new one in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
    else $error("result register refilled too early");

    // Planes stay within the configured count.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(plane_index) < PLANE_COUNT))
    else $error("plane_index out of range");

endmodule

bind bar_graph_led_matrix_bcm_driver_top bglm_checker u_bglm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .row_index     (row_index),
    .plane_index   (plane_index),
    .blank_first   (blank_first),
    .blue_bits     (blue_bits),
    .green_bits    (green_bits),
    .red_bits      (red_bits),
    .period_cycles (period_cycles)
);
